FILE: sv/bitmap_block_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Bitmap block allocator: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication
`define BBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap allocator check failed");

// Next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap allocator check failed");

`endif

FILE: sv/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, codes and the word scan request/result types.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Bitmap word geometry
  localparam int WORD_W  = 32;
  localparam int WORD_LG = 5;

  // Field widths
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int BLK_W     = 12;
  localparam int STAT_W    = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT      = 1'b1;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE   = 2'd2;

  // One word handed to the scan unit, with optional edge trims
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic               lo_en;
    logic [WORD_LG-1:0] lo_bit;
    logic               hi_en;
    logic [WORD_LG-1:0] hi_bit;
  } scan_req_t;

  // Lowest free bit in range and the word with that bit taken
  typedef struct packed {
    logic               found;
    logic [WORD_LG-1:0] bit_idx;
    logic [WORD_W-1:0]  cleared;
  } scan_res_t;

endpackage

FILE: sv/bba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator channels
// Valid/ready request and result channels with their payloads.
// ----------------------------------------------------------------------------
interface bba_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [bba_pkg::BLK_W-1:0]    block_number;

  modport source (output valid, kind, block_number, input ready);
  modport sink   (input valid, kind, block_number, output ready);
endinterface

interface bba_out_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::STAT_W-1:0]   status;
  logic [bba_pkg::BLK_W-1:0]    granted_block;

  modport source (output valid, status, granted_block, input ready);
  modport sink   (input valid, status, granted_block, output ready);
endinterface

FILE: sv/bba_word_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap word scan unit
// Trims one bitmap word to the scan window and finds its lowest free bit.
// ----------------------------------------------------------------------------
module bba_word_scan (
  input  bba_pkg::scan_req_t req,
  output bba_pkg::scan_res_t res
);

  logic [bba_pkg::WORD_W-1:0]  lo_mask;
  logic [bba_pkg::WORD_W-1:0]  hi_mask;
  logic [bba_pkg::WORD_W-1:0]  masked;
  logic [bba_pkg::WORD_LG-1:0] idx;

  // Window trims at the first and last word of the range
  assign lo_mask = req.lo_en ? ({bba_pkg::WORD_W{1'b1}} << req.lo_bit)
                             : {bba_pkg::WORD_W{1'b1}};
  assign hi_mask = req.hi_en
                 ? ({bba_pkg::WORD_W{1'b1}} >>
                    (bba_pkg::WORD_LG'(bba_pkg::WORD_W - 1) - req.hi_bit))
                 : {bba_pkg::WORD_W{1'b1}};
  assign masked  = req.word & lo_mask & hi_mask;

  // Lowest set bit wins
  always_comb begin
    idx = '0;
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        idx = bba_pkg::WORD_LG'(i);
      end
    end
  end

  assign res.found   = |masked;
  assign res.bit_idx = idx;
  assign res.cleared = req.word & ~(bba_pkg::WORD_W'(1) << idx);

endmodule

FILE: sv/bitmap_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator core
// First-fit free-block bitmap with allocate and free requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request item: kind (0 allocate, 1 free) and block_number.
//   out_ch returns exactly one item per request: status and granted_block.
//   cfg_we/cfg_index/cfg_wdata set first_data_block (0) and block_limit (1);
//   write them only while no request is in flight.
//   The bitmap sits in a RAM of 32-bit words, one read and one write port.
//   Allocate reads one word per cycle and tests it in the word scan unit;
//   it scans the words from first_data_block up to the block found or the
//   window end, at most 128 for 4096 blocks; an empty window answers with
//   no scan. Free is a read-modify-write of one word; an out-of-range free
//   answers without touching the bitmap. The next request can be accepted
//   in the cycle after the result is loaded.
//   One request is in work at a time; in_ch.ready is high only between items.
//   The output register holds a result until out_ch.ready; the next request
//   is accepted meanwhile and waits before its own result until the slot
//   frees up.
//   Reset sets both registers to 0 and clears the bitmap (nothing free) in
//   a pass over its ceil(NUM_BLOCKS/32) words, accepting no request meanwhile.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bba_in_if.sink                          in_ch,
  bba_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int NUM_WORDS = (NUM_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
  localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [bba_pkg::CFG_W-1:0] NB_CAP = bba_pkg::CFG_W'(NUM_BLOCKS);

  typedef enum logic [5:0] {
    ST_CLR     = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_SETUP   = 6'b000100,
    ST_SCAN    = 6'b001000,
    ST_FREE_WR = 6'b010000,
    ST_POST    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [bba_pkg::CFG_W-1:0]   fdb_r;
  logic [bba_pkg::CFG_W-1:0]   lim_r;

  // Request and scan window
  logic                        kind_r;
  logic [bba_pkg::BLK_W-1:0]   bno_r;
  logic [WA-1:0]               start_w_r;
  logic [WA-1:0]               end_w_r;
  logic [bba_pkg::WORD_LG-1:0] lo_r;
  logic [bba_pkg::WORD_LG-1:0] hi_r;
  logic [WA-1:0]               rd_ptr_r;
  logic [WA-1:0]               chk_ptr_r;
  logic                        chk_v_r;

  // Pending result and output register
  logic [bba_pkg::STAT_W-1:0]  res_status_r;
  logic [bba_pkg::BLK_W-1:0]   res_grant_r;
  logic                        out_valid_r;
  logic [bba_pkg::STAT_W-1:0]  out_status_r;
  logic [bba_pkg::BLK_W-1:0]   out_grant_r;

  // Bitmap RAM
  logic [bba_pkg::WORD_W-1:0]  mem [NUM_WORDS];
  logic [bba_pkg::WORD_W-1:0]  rd_data_r;
  logic                        mem_we;
  logic [WA-1:0]               mem_waddr;
  logic [bba_pkg::WORD_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [WA-1:0]               mem_raddr;

  // Derived control
  logic                        in_acc;
  logic                        free_in_range;
  logic [bba_pkg::CFG_W-1:0]   lim_eff;
  logic [bba_pkg::CFG_W-1:0]   lim_m1;
  logic                        scan_empty;
  logic                        out_load;
  logic [WA+bba_pkg::WORD_LG-1:0] grant_full;

  bba_pkg::scan_req_t          scan_req;
  bba_pkg::scan_res_t          scan_res;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign free_in_range = (32'(in_ch.block_number) < NUM_BLOCKS);

  // Effective limit is capped at the bitmap capacity
  assign lim_eff    = (32'(lim_r) > NUM_BLOCKS) ? NB_CAP : lim_r;
  assign lim_m1     = lim_eff - 1'b1;
  assign scan_empty = (fdb_r >= lim_eff);

  assign out_load   = (state_r == ST_POST) && (!out_valid_r || out_ch.ready);

  // Word scan unit on the word just read
  assign scan_req.word   = rd_data_r;
  assign scan_req.lo_en  = (chk_ptr_r == start_w_r);
  assign scan_req.lo_bit = lo_r;
  assign scan_req.hi_en  = (chk_ptr_r == end_w_r);
  assign scan_req.hi_bit = hi_r;

  bba_word_scan u_scan (
    .req (scan_req),
    .res (scan_res)
  );

  assign grant_full = {chk_ptr_r, scan_res.bit_idx};

  // Sequencer and RAM port control
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = chk_ptr_r;
    mem_wdata = scan_res.cleared;
    mem_re    = 1'b0;
    mem_raddr = rd_ptr_r;
    unique case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = rd_ptr_r;
        mem_wdata = '0;
        if (rd_ptr_r == WA'(NUM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind == bba_pkg::KIND_FREE) begin
            if (free_in_range) begin
              mem_re    = 1'b1;
              mem_raddr = WA'(in_ch.block_number >> bba_pkg::WORD_LG);
              state_nxt = ST_FREE_WR;
            end else begin
              state_nxt = ST_POST;
            end
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        state_nxt = scan_empty ? ST_POST : ST_SCAN;
      end
      ST_SCAN: begin
        mem_re = (rd_ptr_r <= end_w_r);
        if (chk_v_r) begin
          if (scan_res.found) begin
            mem_we    = 1'b1;
            state_nxt = ST_POST;
          end else if (chk_ptr_r == end_w_r) begin
            state_nxt = ST_POST;
          end
        end
      end
      ST_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = WA'(bno_r >> bba_pkg::WORD_LG);
        mem_wdata = rd_data_r |
                    (bba_pkg::WORD_W'(1) << bno_r[bba_pkg::WORD_LG-1:0]);
        state_nxt = ST_POST;
      end
      ST_POST: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Bitmap RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      rd_ptr_r    <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      fdb_r       <= '0;
      lim_r       <= '0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          bba_pkg::CFG_FIRST_DATA_BLOCK: fdb_r <= cfg_wdata;
          bba_pkg::CFG_BLOCK_LIMIT:      lim_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Read pointer doubles as the clear pointer
      if (state_r == ST_CLR || state_r == ST_SCAN) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end else if (state_r == ST_SETUP) begin
        rd_ptr_r <= WA'(fdb_r >> bba_pkg::WORD_LG);
      end

      if (state_r == ST_SCAN) begin
        chk_v_r <= mem_re;
      end else begin
        chk_v_r <= 1'b0;
      end

      // Output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r       <= in_ch.kind;
      bno_r        <= in_ch.block_number;
      res_status_r <= (in_ch.kind == bba_pkg::KIND_FREE && !free_in_range)
                    ? bba_pkg::STATUS_RANGE : bba_pkg::STATUS_OK;
      res_grant_r  <= '0;
    end
    if (state_r == ST_SETUP) begin
      start_w_r <= WA'(fdb_r >> bba_pkg::WORD_LG);
      end_w_r   <= WA'(lim_m1 >> bba_pkg::WORD_LG);
      lo_r      <= fdb_r[bba_pkg::WORD_LG-1:0];
      hi_r      <= lim_m1[bba_pkg::WORD_LG-1:0];
      if (scan_empty) begin
        res_status_r <= bba_pkg::STATUS_NOSPACE;
      end
    end
    if (state_r == ST_SCAN) begin
      chk_ptr_r <= rd_ptr_r;
      if (chk_v_r) begin
        if (scan_res.found) begin
          res_status_r <= bba_pkg::STATUS_OK;
          res_grant_r  <= bba_pkg::BLK_W'(grant_full);
        end else if (chk_ptr_r == end_w_r) begin
          res_status_r <= bba_pkg::STATUS_NOSPACE;
        end
      end
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_grant_r  <= (kind_r == bba_pkg::KIND_ALLOC) ? res_grant_r : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.granted_block = out_grant_r;

  // Checks
  `include "bitmap_block_allocator_core_assert.svh"

  `BBA_ASSERT_NOW(a_no_write_idle, state_r == ST_IDLE, !mem_we)
  `BBA_ASSERT_NOW(a_grant_in_window,
                  state_r == ST_SCAN && chk_v_r && scan_res.found,
                  grant_full >= fdb_r && grant_full < lim_eff)
  `BBA_ASSERT_NEXT(a_post_holds,
                   state_r == ST_POST && out_valid_r && !out_ch.ready,
                   state_r == ST_POST)

endmodule

FILE: tb/bba_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator scoreboard
// Watches the request, result and register ports, keeps its own copy of the
// free map and registers, predicts each answer and checks it in order.
// ----------------------------------------------------------------------------
module bba_scoreboard #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bba_in_if                             in_ch,
  bba_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending,
  output int                            n_grants,
  output int                            n_nospace,
  output int                            n_frees
);
  import bba_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  granted_block;
  } answer_t;

  // Shadow state: one bit per block, set means free
  bit                block_free [NUM_BLOCKS];
  logic [CFG_W-1:0]  scan_floor;
  logic [CFG_W-1:0]  scan_limit;
  answer_t           pending_answers [$];

  // First-fit allocate or free on the shadow map
  function automatic answer_t allocate_or_free(logic kind, logic [BLK_W-1:0] bno);
    answer_t a;
    int      top;
    int      b;
    bit      found;
    a.status        = STATUS_OK;
    a.granted_block = '0;
    if (kind == KIND_ALLOC) begin
      // a limit past capacity is clamped to the map size
      top      = (scan_limit > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_limit);
      found    = 1'b0;
      a.status = STATUS_NOSPACE;
      for (b = int'(scan_floor); b < top && !found; b++) begin
        if (block_free[b]) begin
          block_free[b]   = 1'b0;
          a.granted_block = b[BLK_W-1:0];
          a.status        = STATUS_OK;
          found           = 1'b1;
        end
      end
    end else if (int'(bno) >= NUM_BLOCKS) begin
      a.status = STATUS_RANGE;
    end else begin
      // blocks outside the scan window are still marked free
      block_free[bno] = 1'b1;
    end
    return a;
  endfunction

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (!rst_n) begin
      foreach (block_free[i]) block_free[i] = 1'b0;
      scan_floor = '0;
      scan_limit = '0;
      pending_answers.delete();
      fail_count = 0;
      pending    = 0;
      n_grants   = 0;
      n_nospace  = 0;
      n_frees    = 0;
    end else begin
      // register writes only come while idle
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_DATA_BLOCK: scan_floor = cfg_wdata;
          CFG_BLOCK_LIMIT:      scan_limit = cfg_wdata;
          default: ;
        endcase
      end

      // result item: compare with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got.status        = out_ch.status;
        got.granted_block = out_ch.granted_block;
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result, got status %0d block %0d",
                   $time, got.status, got.granted_block);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          if (want.status != got.status || want.granted_block != got.granted_block) begin
            $display("%0t: result mismatch, expected status %0d block %0d, got status %0d block %0d",
                     $time, want.status, want.granted_block, got.status, got.granted_block);
            fail_count++;
          end
        end
      end

      // request item: predict its answer
      if (in_ch.valid && in_ch.ready) begin
        want = allocate_or_free(in_ch.kind, in_ch.block_number);
        if (in_ch.kind == KIND_FREE) n_frees++;
        else if (want.status == STATUS_OK) n_grants++;
        else n_nospace++;
        pending_answers.push_back(want);
      end

      pending = pending_answers.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate and free requests under a series of scan windows, with
// random idle cycles on both channels; the scoreboard checks every answer.
// ----------------------------------------------------------------------------
module testbench;
  import bba_pkg::*;

  localparam int NUM_BLOCKS = 4096;
  localparam int CYCLE_LIMIT = 600000;
  localparam int END_SLACK = 140;
  localparam int PHASE_ITEMS = 100;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  int fail_count;
  int pending;
  int n_grants;
  int n_nospace;
  int n_frees;
  int n_items;
  int n_settings;
  int cycles;
  bit no_idle;

  bitmap_block_allocator_core #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bba_scoreboard #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .n_grants   (n_grants),
    .n_nospace  (n_nospace),
    .n_frees    (n_frees)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d answers outstanding", cycles, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 17);
    end
  end

  // One request item, with random idle cycles ahead of it
  task automatic send_item(logic kind, logic [BLK_W-1:0] bno);
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.block_number <= bno;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  // Drain, then write both registers
  task automatic write_config(logic [CFG_W-1:0] floor_blk, logic [CFG_W-1:0] limit_blk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_DATA_BLOCK;
    cfg_wdata <= floor_blk;
    @(negedge clk);
    cfg_index <= CFG_BLOCK_LIMIT;
    cfg_wdata <= limit_blk;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Random mix of allocs and frees; most frees land inside the scan window
  task automatic run_phase(int floor_blk, int limit_blk, int count);
    int top;
    int i;
    logic [BLK_W-1:0] bno;
    write_config(floor_blk[CFG_W-1:0], limit_blk[CFG_W-1:0]);
    top = (limit_blk > NUM_BLOCKS) ? NUM_BLOCKS : limit_blk;
    for (i = 0; i < count; i++) begin
      if (floor_blk < top && $urandom_range(0, 99) < 70)
        bno = BLK_W'($urandom_range(floor_blk, top - 1));
      else
        bno = BLK_W'($urandom_range(0, (1 << BLK_W) - 1));
      if ($urandom_range(0, 1) == 0) send_item(KIND_ALLOC, bno);
      else send_item(KIND_FREE, bno);
    end
  endtask

  initial begin
    int fl;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_FIRST_DATA_BLOCK;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_ALLOC;
    in_ch.block_number = '0;
    no_idle            = 1'b0;
    n_items            = 0;
    n_settings         = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers: empty scan window, free outside it
    send_item(KIND_ALLOC, 12'd0);
    send_item(KIND_FREE, 12'd0);
    send_item(KIND_ALLOC, 12'hFFF);

    // Full window
    write_config(13'd0, 13'd4096);
    send_item(KIND_ALLOC, 12'd0);
    send_item(KIND_ALLOC, 12'd0);
    send_item(KIND_FREE, 12'd4095);
    send_item(KIND_FREE, 12'd4095);   // double free
    send_item(KIND_FREE, 12'd2048);
    send_item(KIND_ALLOC, 12'd0);
    send_item(KIND_ALLOC, 12'd0);
    send_item(KIND_FREE, 12'd5);
    send_item(KIND_FREE, 12'd6);
    send_item(KIND_ALLOC, 12'd0);

    // Limit past capacity is clamped; free below the floor stays hidden
    write_config(13'd6, 13'h1FFF);
    send_item(KIND_FREE, 12'd3);
    send_item(KIND_ALLOC, 12'd0);
    send_item(KIND_ALLOC, 12'd0);
    send_item(KIND_FREE, 12'd4095);
    send_item(KIND_ALLOC, 12'd0);

    // Floor at capacity
    write_config(13'd4096, 13'd4096);
    send_item(KIND_FREE, 12'd100);
    send_item(KIND_ALLOC, 12'd0);

    // One-block window
    write_config(13'd100, 13'd101);
    send_item(KIND_ALLOC, 12'd0);
    send_item(KIND_FREE, 12'hAAA);
    send_item(KIND_FREE, 12'h555);

    // Random phases over several windows
    run_phase(0, 4096, PHASE_ITEMS);
    fl = $urandom_range(0, 200);
    run_phase(fl, fl + $urandom_range(32, 300), PHASE_ITEMS);
    no_idle = 1'b1;
    run_phase(0, 8191, PHASE_ITEMS);
    no_idle = 1'b0;
    run_phase($urandom_range(0, 4096), $urandom_range(0, 8191), PHASE_ITEMS);
    run_phase(3000, 2000, PHASE_ITEMS);
    run_phase(4000, 4096, PHASE_ITEMS);

    // Drain and let any stray result show up
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (END_SLACK) @(posedge clk);

    $display("Ran %0d requests over %0d register settings:", n_items, n_settings);
    $display("  %0d grants, %0d no-space answers, %0d frees", n_grants, n_nospace, n_frees);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
